FILE: src/sdes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S-DES CTR keystream package
// Shared widths, register indexes, subkey bundle and the S-DES network
// (key schedule, Feistel round, initial and final permutations).
// ----------------------------------------------------------------------------
package sdes_pkg;

    localparam int KEY_W  = 10;
    localparam int BYTE_W = 8;
    localparam int SK_W   = 8;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic REG_CIPHER_KEY    = 1'b0;
    localparam logic REG_START_COUNTER = 1'b1;

    typedef struct packed {
        logic [SK_W-1:0] k1;
        logic [SK_W-1:0] k2;
    } t_subkeys;

    localparam logic [1:0] BOX0 [0:15] = '{
        2'd1, 2'd0, 2'd3, 2'd2,
        2'd3, 2'd2, 2'd1, 2'd0,
        2'd0, 2'd2, 2'd1, 2'd3,
        2'd3, 2'd1, 2'd3, 2'd2
    };

    localparam logic [1:0] BOX1 [0:15] = '{
        2'd0, 2'd1, 2'd2, 2'd3,
        2'd2, 2'd0, 2'd1, 2'd3,
        2'd3, 2'd0, 2'd1, 2'd0,
        2'd2, 2'd1, 2'd0, 2'd3
    };

    function automatic logic [9:0] p10(input logic [9:0] b);
        return {b[7], b[5], b[8], b[3], b[6], b[0], b[9], b[1], b[2], b[4]};
    endfunction

    function automatic logic [7:0] p8(input logic [9:0] b);
        return {b[4], b[7], b[3], b[6], b[2], b[5], b[0], b[1]};
    endfunction

    function automatic logic [7:0] ip(input logic [7:0] b);
        return {b[6], b[2], b[5], b[7], b[4], b[0], b[3], b[1]};
    endfunction

    function automatic logic [7:0] ip_inv(input logic [7:0] b);
        return {b[4], b[7], b[5], b[3], b[1], b[6], b[0], b[2]};
    endfunction

    function automatic logic [7:0] ep(input logic [3:0] b);
        return {b[0], b[3], b[2], b[1], b[2], b[1], b[0], b[3]};
    endfunction

    function automatic logic [3:0] p4(input logic [3:0] b);
        return {b[2], b[0], b[1], b[3]};
    endfunction

    function automatic logic [4:0] rot1(input logic [4:0] h);
        return {h[3:0], h[4]};
    endfunction

    function automatic logic [4:0] rot2(input logic [4:0] h);
        return {h[2:0], h[4:3]};
    endfunction

    function automatic t_subkeys key_sched(input logic [KEY_W-1:0] key);
        logic [9:0] k;
        logic [4:0] hl;
        logic [4:0] hr;
        t_subkeys   sk;
        k     = p10(key);
        hl    = rot1(k[9:5]);
        hr    = rot1(k[4:0]);
        sk.k1 = p8({hl, hr});
        hl    = rot2(hl);
        hr    = rot2(hr);
        sk.k2 = p8({hl, hr});
        return sk;
    endfunction

    function automatic logic [3:0] round_f(input logic [3:0] half, input logic [SK_W-1:0] sk);
        logic [7:0] e;
        logic [3:0] s;
        e = ep(half) ^ sk;
        s = {BOX0[{e[7], e[4], e[6:5]}], BOX1[{e[3], e[0], e[2:1]}]};
        return p4(s);
    endfunction

    function automatic logic [BYTE_W-1:0] sdes_block_enc(input logic [BYTE_W-1:0] blk,
                                                         input t_subkeys sk);
        logic [7:0] x;
        logic [3:0] l;
        logic [3:0] r;
        logic [3:0] t;
        x = ip(blk);
        l = x[7:4];
        r = x[3:0];
        t = l ^ round_f(r, sk.k1);
        l = r;
        r = t;
        l = l ^ round_f(r, sk.k2);
        return ip_inv({l, r});
    endfunction

endpackage

FILE: src/sdes_ctr_keystream_cipher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S-DES CTR keystream cipher core
// Input register captures each transaction at the accepting edge; the result
// register loads from it when the output is free. Throughput: one byte per cycle
// unless the output stalls, set by the single S-DES network between the two.
// Reset: synchronous active low; clears key, start value and counter to zero.
// ----------------------------------------------------------------------------
module sdes_ctr_keystream_cipher_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [sdes_pkg::ADDR_W-1:0] i_paddr,
    input  logic [sdes_pkg::DATA_W-1:0] i_pwdata,
    output logic [sdes_pkg::DATA_W-1:0] o_prdata,
    output logic                        o_pready,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [sdes_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                        i_message_end,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [sdes_pkg::BYTE_W-1:0] o_result_byte
);
    import sdes_pkg::*;

    t_subkeys          subkeys;
    logic [BYTE_W-1:0] start_counter;
    logic [BYTE_W-1:0] r_ctr;
    logic [BYTE_W-1:0] r_s1_ctr;
    logic [BYTE_W-1:0] r_s1_data;
    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_valid;
    logic [BYTE_W-1:0] n_out_byte;
    logic              in_accept;
    logic              out_load;

    sdes_apb_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_psel          (i_psel),
        .i_penable       (i_penable),
        .i_pwrite        (i_pwrite),
        .i_paddr         (i_paddr),
        .i_pwdata        (i_pwdata),
        .o_prdata        (o_prdata),
        .o_pready        (o_pready),
        .o_subkeys       (subkeys),
        .o_start_counter (start_counter)
    );

    sdes_engine u_engine (
        .i_counter (r_s1_ctr),
        .i_data    (r_s1_data),
        .i_subkeys (subkeys),
        .o_result  (n_out_byte)
    );

    assign out_load  = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_s1_valid || out_load;
    assign in_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_ctr <= i_message_end ? start_counter : r_ctr + 1'b1;
            end
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (out_load) begin
                r_s1_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_ctr  <= r_ctr;
            r_s1_data <= i_data_byte;
        end
        if (out_load) begin
            r_out_byte <= n_out_byte;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_result_byte = r_out_byte;

    a_ctr_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && !i_message_end |=> r_ctr == $past(r_ctr) + 1'b1)
        else $error("counter did not advance after a transaction");

    a_ctr_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_message_end |=> r_ctr == $past(start_counter))
        else $error("counter did not reload after message end");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !out_load |=> r_s1_valid && $stable(r_s1_ctr) && $stable(r_s1_data))
        else $error("input stage lost a transaction");

    a_stage_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_s1_valid && r_s1_ctr == $past(r_ctr))
        else $error("accepted transaction not captured");

endmodule

FILE: src/sdes_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S-DES APB register bank
// Holds the cipher key and the counter start value; registers the two
// subkeys derived from the key.
// ----------------------------------------------------------------------------
module sdes_apb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [sdes_pkg::ADDR_W-1:0] i_paddr,
    input  logic [sdes_pkg::DATA_W-1:0] i_pwdata,
    output logic [sdes_pkg::DATA_W-1:0] o_prdata,
    output logic                        o_pready,
    output sdes_pkg::t_subkeys          o_subkeys,
    output logic [sdes_pkg::BYTE_W-1:0] o_start_counter
);
    import sdes_pkg::*;

    logic [KEY_W-1:0]  r_cipher_key;
    logic [BYTE_W-1:0] r_start_counter;
    t_subkeys          r_subkeys;
    t_subkeys          n_subkeys;
    logic              wr_en;
    logic              reg_idx;

    assign wr_en     = i_psel && i_penable && i_pwrite;
    assign reg_idx   = i_paddr[2];
    assign n_subkeys = key_sched(r_cipher_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cipher_key    <= '0;
            r_start_counter <= '0;
            r_subkeys       <= key_sched('0);
        end else begin
            r_subkeys <= n_subkeys;
            if (wr_en) begin
                case (reg_idx)
                    REG_CIPHER_KEY:    r_cipher_key    <= i_pwdata[KEY_W-1:0];
                    REG_START_COUNTER: r_start_counter <= i_pwdata[BYTE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CIPHER_KEY:    o_prdata = {{(DATA_W-KEY_W){1'b0}}, r_cipher_key};
            REG_START_COUNTER: o_prdata = {{(DATA_W-BYTE_W){1'b0}}, r_start_counter};
            default:           o_prdata = '0;
        endcase
    end

    assign o_pready        = 1'b1;
    assign o_subkeys       = r_subkeys;
    assign o_start_counter = r_start_counter;

endmodule

FILE: src/sdes_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S-DES keystream combiner
// Encrypts the counter block under the subkeys and XORs the keystream byte
// into the data byte.
// ----------------------------------------------------------------------------
module sdes_engine (
    input  logic [sdes_pkg::BYTE_W-1:0] i_counter,
    input  logic [sdes_pkg::BYTE_W-1:0] i_data,
    input  sdes_pkg::t_subkeys          i_subkeys,
    output logic [sdes_pkg::BYTE_W-1:0] o_result
);
    import sdes_pkg::*;

    logic [BYTE_W-1:0] keystream;

    assign keystream = sdes_block_enc(i_counter, i_subkeys);
    assign o_result  = i_data ^ keystream;

endmodule

FILE: verif/sdes_ctr_keystream_cipher_core_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S-DES CTR keystream cipher core result check
// Follows register writes on the APB port, computes the keystream byte for
// every accepted input transaction from its own copy of key, start value and
// counter, and compares each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module sdes_ctr_keystream_cipher_core_check (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [sdes_pkg::ADDR_W-1:0] i_paddr,
    input  logic [sdes_pkg::DATA_W-1:0] i_pwdata,
    input  logic                        i_pready,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [sdes_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                        i_message_end,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [sdes_pkg::BYTE_W-1:0] i_result_byte,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_compared
);

    // Permutation tables, bit 1 = MSB, first entry in the top used nibble.
    localparam logic [39:0] P10_TAB   = {4'd3, 4'd5, 4'd2, 4'd7, 4'd4,
                                         4'd10, 4'd1, 4'd9, 4'd8, 4'd6};
    localparam logic [39:0] P8_TAB    = {8'd0, 4'd6, 4'd3, 4'd7, 4'd4,
                                         4'd8, 4'd5, 4'd10, 4'd9};
    localparam logic [39:0] IP_TAB    = {8'd0, 4'd2, 4'd6, 4'd3, 4'd1,
                                         4'd4, 4'd8, 4'd5, 4'd7};
    localparam logic [39:0] IPINV_TAB = {8'd0, 4'd4, 4'd1, 4'd3, 4'd5,
                                         4'd7, 4'd2, 4'd8, 4'd6};
    localparam logic [39:0] EP_TAB    = {8'd0, 4'd4, 4'd1, 4'd2, 4'd3,
                                         4'd2, 4'd3, 4'd4, 4'd1};
    localparam logic [39:0] P4_TAB    = {24'd0, 4'd2, 4'd4, 4'd3, 4'd1};

    // S-boxes, row-major, entry 0 in the top two bits.
    localparam logic [31:0] SBOX_LEFT  = {2'd1, 2'd0, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0,
                                          2'd0, 2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd3, 2'd2};
    localparam logic [31:0] SBOX_RIGHT = {2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3,
                                          2'd3, 2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3};

    logic [9:0] cur_key;
    logic [7:0] cur_start;
    logic [7:0] keystream_ctr;
    logic [7:0] expected_result_bytes[$];
    int         fails;
    int         compared;

    function automatic logic [9:0] permute(input logic [9:0] v, input int w,
                                           input logic [39:0] tab, input int n);
        logic [9:0] r;
        int         p;
        r = '0;
        for (int i = 0; i < n; i++) begin
            p = tab[4*(n-1-i) +: 4];
            r = {r[8:0], v[w-p]};
        end
        return r;
    endfunction

    function automatic logic [4:0] rotl5(input logic [4:0] h, input int s);
        logic [9:0] d;
        d = {h, h};
        return d[9-s -: 5];
    endfunction

    function automatic logic [1:0] sbox(input logic [3:0] nib, input logic [31:0] box);
        int idx;
        idx = {nib[3], nib[0]} * 4 + nib[2:1];
        return box[2*(15-idx) +: 2];
    endfunction

    function automatic logic [3:0] feistel(input logic [3:0] half, input logic [7:0] sk);
        logic [9:0] tmp;
        logic [7:0] e;
        tmp = permute({6'd0, half}, 4, EP_TAB, 8);
        e   = tmp[7:0] ^ sk;
        tmp = permute({6'd0, sbox(e[7:4], SBOX_LEFT), sbox(e[3:0], SBOX_RIGHT)}, 4, P4_TAB, 4);
        return tmp[3:0];
    endfunction

    function automatic logic [7:0] sdes_keystream(input logic [7:0] ctr, input logic [9:0] key);
        logic [9:0] tmp;
        logic [4:0] hl;
        logic [4:0] hr;
        logic [7:0] k1;
        logic [7:0] k2;
        logic [3:0] l;
        logic [3:0] r;
        logic [3:0] t;
        tmp = permute(key, 10, P10_TAB, 10);
        hl  = rotl5(tmp[9:5], 1);
        hr  = rotl5(tmp[4:0], 1);
        tmp = permute({hl, hr}, 10, P8_TAB, 8);
        k1  = tmp[7:0];
        hl  = rotl5(hl, 2);
        hr  = rotl5(hr, 2);
        tmp = permute({hl, hr}, 10, P8_TAB, 8);
        k2  = tmp[7:0];
        tmp = permute({2'd0, ctr}, 8, IP_TAB, 8);
        l   = tmp[7:4];
        r   = tmp[3:0];
        t   = l ^ feistel(r, k1);
        l   = r;
        r   = t;
        l   = l ^ feistel(r, k2);
        tmp = permute({2'd0, l, r}, 8, IPINV_TAB, 8);
        return tmp[7:0];
    endfunction

    always @(posedge i_clk) begin
        logic [7:0] want;
        if (!i_rst_n) begin
            cur_key       = '0;
            cur_start     = '0;
            keystream_ctr = '0;
            expected_result_bytes.delete();
            fails         = 0;
            compared      = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[sdes_pkg::ADDR_W-1:2])
                    sdes_pkg::REG_CIPHER_KEY:    cur_key   = i_pwdata[9:0];
                    sdes_pkg::REG_START_COUNTER: cur_start = i_pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_result_bytes.size() == 0) begin
                    $error("result_byte with no transaction pending: actual %02h",
                           i_result_byte);
                    fails++;
                end else begin
                    want = expected_result_bytes.pop_front();
                    compared++;
                    if (i_result_byte !== want) begin
                        $error("result_byte mismatch: expected %02h, actual %02h",
                               want, i_result_byte);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_result_bytes.push_back(i_data_byte ^ sdes_keystream(keystream_ctr,
                                                                              cur_key));
                keystream_ctr = i_message_end ? cur_start : keystream_ctr + 8'd1;
            end
        end
        o_pending    <= expected_result_bytes.size();
        o_fail_count <= fails;
        o_compared   <= compared;
    end

endmodule

FILE: verif/sdes_ctr_keystream_cipher_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S-DES CTR keystream cipher core testbench
// Drives directed byte streams (field extremes, counter wrap, back-to-back
// message ends, start value and key changes) and then random messages under
// several key and start settings, with random gaps and stalls on both sides
// and one long output stall. Results are checked by the companion checker.
// ----------------------------------------------------------------------------
module sdes_ctr_keystream_cipher_core_tb;

    localparam int HOLD_CYCLES      = 400;
    localparam int PHASES           = 6;
    localparam int ITEMS_PER_PHASE  = 155;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        i_psel        = 1'b0;
    logic                        i_penable     = 1'b0;
    logic                        i_pwrite      = 1'b0;
    logic [sdes_pkg::ADDR_W-1:0] i_paddr       = '0;
    logic [sdes_pkg::DATA_W-1:0] i_pwdata      = '0;
    logic [sdes_pkg::DATA_W-1:0] o_prdata;
    logic                        o_pready;
    logic                        i_valid       = 1'b0;
    logic                        o_ready;
    logic [sdes_pkg::BYTE_W-1:0] i_data_byte   = '0;
    logic                        i_message_end = 1'b0;
    logic                        o_valid;
    logic                        i_ready       = 1'b0;
    logic [sdes_pkg::BYTE_W-1:0] o_result_byte;

    int fail_count;
    int pending;
    int compared;
    int bytes_sent;
    int messages_sent;
    int random_sent;
    int burst_left;
    bit hold_req;
    bit hold_done;

    sdes_ctr_keystream_cipher_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (i_psel),
        .i_penable     (i_penable),
        .i_pwrite      (i_pwrite),
        .i_paddr       (i_paddr),
        .i_pwdata      (i_pwdata),
        .o_prdata      (o_prdata),
        .o_pready      (o_pready),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_message_end (i_message_end),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result_byte (o_result_byte)
    );

    sdes_ctr_keystream_cipher_core_check u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (i_psel),
        .i_penable     (i_penable),
        .i_pwrite      (i_pwrite),
        .i_paddr       (i_paddr),
        .i_pwdata      (i_pwdata),
        .i_pready      (o_pready),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_data_byte   (i_data_byte),
        .i_message_end (i_message_end),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_result_byte (o_result_byte),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_compared    (compared)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int next_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(20, 60);
        return pick_gap();
    endfunction

    task automatic write_reg(input logic idx, input logic [31:0] value);
        logic [31:0] junk;
        junk = $urandom();
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= (idx == sdes_pkg::REG_CIPHER_KEY) ? {junk[31:10], value[9:0]}
                                                       : {junk[31:8], value[7:0]};
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] data, input logic msg_end, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_data_byte   <= data;
        i_message_end <= msg_end;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
        if (msg_end) messages_sent++;
    endtask

    // Drop valid and let every pending transaction drain.
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_messages(input int n_items);
        int   sent;
        int   len;
        bit   broken;
        logic msg_end;
        sent = 0;
        while (sent < n_items) begin
            len    = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
            broken = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < len && sent < n_items; i++) begin
                msg_end = (i == len - 1);
                if (broken) msg_end = ($urandom_range(0, 5) == 0);
                send_byte(8'($urandom_range(0, 255)), msg_end, next_gap());
                sent++;
                random_sent++;
                if (random_sent == 200) hold_req = 1'b1;
            end
        end
    endtask

    // Output side: random stalls, ready bursts and one long hold-off.
    initial begin
        forever begin
            int gap;
            if (hold_req && !hold_done) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else if ($urandom_range(0, 9) == 0) begin
                i_ready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge i_clk);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    i_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        logic [9:0] key;
        logic [7:0] start;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(sdes_pkg::REG_CIPHER_KEY, 32'h000);
        write_reg(sdes_pkg::REG_START_COUNTER, 32'h00);
        send_byte(8'h00, 1'b0, 0);
        send_byte(8'hFF, 1'b0, 0);
        send_byte(8'h55, 1'b0, 1);
        send_byte(8'hAA, 1'b1, 0);
        send_byte(8'hFF, 1'b1, 0);
        drain();

        // New start value only lands at the next message end; then wrap 255 -> 0.
        write_reg(sdes_pkg::REG_START_COUNTER, 32'hFF);
        send_byte(8'h0F, 1'b1, 0);
        send_byte(8'hF0, 1'b0, 0);
        send_byte(8'h3C, 1'b0, 2);
        send_byte(8'hC3, 1'b0, 0);
        drain();

        // Key change in the middle of a message.
        write_reg(sdes_pkg::REG_CIPHER_KEY, 32'h3FF);
        send_byte(8'h00, 1'b0, 0);
        send_byte(8'hFF, 1'b0, 0);
        send_byte(8'h81, 1'b1, 0);
        send_byte(8'h7E, 1'b0, 0);
        drain();

        write_reg(sdes_pkg::REG_CIPHER_KEY, 32'h2AA);
        write_reg(sdes_pkg::REG_START_COUNTER, 32'h80);
        send_byte(8'h01, 1'b0, 0);
        send_byte(8'h80, 1'b1, 0);
        send_byte(8'hFE, 1'b0, 0);
        send_byte(8'h7F, 1'b1, 0);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            key   = (p == 0) ? 10'h3FF : (p == 1) ? 10'h000 : 10'($urandom_range(0, 1023));
            start = (p == 1) ? 8'hFF : (p == 2) ? 8'h00 : 8'($urandom_range(0, 255));
            write_reg(sdes_pkg::REG_CIPHER_KEY, {22'd0, key});
            write_reg(sdes_pkg::REG_START_COUNTER, {24'd0, start});
            send_messages(ITEMS_PER_PHASE);
            drain();
        end

        $display("Sent %0d bytes in %0d messages under %0d key/start settings",
                 bytes_sent, messages_sent, PHASES + 4);
        $display("Compared %0d results, with gaps, ready bursts and a %0d-cycle output stall",
                 compared, HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: sdes_ctr_keystream_cipher_core.f
src/sdes_pkg.sv
src/sdes_apb_regs.sv
src/sdes_engine.sv
src/sdes_ctr_keystream_cipher_core.sv
verif/sdes_ctr_keystream_cipher_core_check.sv
verif/sdes_ctr_keystream_cipher_core_tb.sv
